// ===== hdl/bpq_pkg.sv =====
// ----------------------------------------------------------------------------
// bpq_pkg
// Shared types and codes for the bucketed priority queue.
// ----------------------------------------------------------------------------
package bpq_pkg;

    // operation codes
    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;

    // result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_EMPTY   = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_BAD_KEY = 2'd3;

    // keys examined per cycle by the minimum search
    localparam int GROUP = 16;

    // sequencer states
    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_INS  = 6'b000010,
        S_SCAN = 6'b000100,
        S_RM1  = 6'b001000,
        S_RM2  = 6'b010000,
        S_DONE = 6'b100000
    } state_t;

endpackage

// ===== hdl/bpq_ram.sv =====
// ----------------------------------------------------------------------------
// bpq_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module bpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== hdl/bucket_priority_queue_fifo.sv =====
// ----------------------------------------------------------------------------
// bucket_priority_queue_fifo
// Min-priority queue with one FIFO linked list per key in a shared store.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries cmd, priority_key, payload_in.
//   A transaction is taken when in_valid is high and in_stall is low.
//   Every command yields exactly one result transaction on the output
//   channel (out_valid/out_stall): payload_out, key_out, queue_empty,
//   entry_count and status.
// Steps, input accept to result valid:
//   clear, error cases, unused code: result set at accept
//   insert: link/tail read, then list update
//   remove: scan of 1 .. ceil(NUM_KEYS/16) groups of 16 key
//   flags, one group per cycle, then head read and entry read.
// One command is in work at a time; in_stall is high until the result
// has been handed to the output register.
// The output register holds a result while out_stall is high; one new
// command may be accepted and worked meanwhile and waits to deliver.
// Reset empties the queue at once (key flags in flip-flops); the entry,
// link, head and tail memories need no clearing pass.
// ----------------------------------------------------------------------------
module bucket_priority_queue_fifo
    import bpq_pkg::*;
#(
    parameter int NUM_KEYS     = 256,
    parameter int CAPACITY     = 1024,
    parameter int PAYLOAD_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  cmd,
    input  logic [7:0]  priority_key,
    input  logic [31:0] payload_in,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] payload_out,
    output logic [7:0]  key_out,
    output logic        queue_empty,
    output logic [10:0] entry_count,
    output logic [1:0]  status
);

    localparam int KEY_W   = $clog2(NUM_KEYS);
    localparam int SLOT_W  = $clog2(CAPACITY);
    localparam int CNT_W   = $clog2(CAPACITY + 1);
    localparam int NGROUPS = (NUM_KEYS + GROUP - 1) / GROUP;
    localparam int GRP_W   = (NGROUPS > 1) ? $clog2(NGROUPS) : 1;

    state_t                  state_reg, state_next;
    logic [1:0]              cmd_reg, cmd_next;
    logic [KEY_W-1:0]        key_reg, key_next;
    logic [PAYLOAD_BITS-1:0] data_reg, data_next;
    logic [SLOT_W-1:0]       slot_reg, slot_next;
    logic [SLOT_W-1:0]       tail_reg, tail_next;
    logic                    from_free_reg, from_free_next;
    logic [GRP_W-1:0]        grp_reg, grp_next;
    logic [NUM_KEYS-1:0]     nonempty_reg, nonempty_next;
    logic [CNT_W-1:0]        free_reg, free_next;
    logic [CNT_W-1:0]        fill_reg, fill_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [PAYLOAD_BITS-1:0] res_payload_reg, res_payload_next;
    logic [KEY_W-1:0]        res_key_reg, res_key_next;
    logic [1:0]              res_status_reg, res_status_next;
    logic                    out_valid_reg, out_valid_next;
    logic [PAYLOAD_BITS-1:0] out_payload_reg;
    logic [KEY_W-1:0]        out_key_reg;
    logic [CNT_W-1:0]        out_count_reg;
    logic [1:0]              out_status_reg;
    logic                    out_load;

    // memory ports
    logic                    pay_we;
    logic [SLOT_W-1:0]       pay_waddr, pay_raddr;
    logic [PAYLOAD_BITS-1:0] pay_wdata, pay_rdata;
    logic                    link_we;
    logic [SLOT_W-1:0]       link_waddr, link_raddr;
    logic [CNT_W-1:0]        link_wdata, link_rdata;
    logic                    head_we;
    logic [KEY_W-1:0]        head_waddr, head_raddr;
    logic [SLOT_W-1:0]       head_wdata, head_rdata;
    logic                    tail_we;
    logic [KEY_W-1:0]        tail_waddr, tail_raddr;
    logic [SLOT_W-1:0]       tail_wdata, tail_rdata;

    // search helpers
    logic [NGROUPS*GROUP-1:0] flags_pad;
    logic [GROUP-1:0]         grp_bits;
    logic [3:0]               grp_enc;
    logic [KEY_W-1:0]         found_key;
    logic                     free_valid;
    logic [SLOT_W-1:0]        new_slot;

    bpq_ram #(.WIDTH(PAYLOAD_BITS), .DEPTH(CAPACITY)) u_payload (
        .clk(clk), .wr_en(pay_we), .wr_addr(pay_waddr), .wr_data(pay_wdata),
        .rd_addr(pay_raddr), .rd_data(pay_rdata)
    );

    bpq_ram #(.WIDTH(CNT_W), .DEPTH(CAPACITY)) u_link (
        .clk(clk), .wr_en(link_we), .wr_addr(link_waddr), .wr_data(link_wdata),
        .rd_addr(link_raddr), .rd_data(link_rdata)
    );

    bpq_ram #(.WIDTH(SLOT_W), .DEPTH(NUM_KEYS)) u_head (
        .clk(clk), .wr_en(head_we), .wr_addr(head_waddr), .wr_data(head_wdata),
        .rd_addr(head_raddr), .rd_data(head_rdata)
    );

    bpq_ram #(.WIDTH(SLOT_W), .DEPTH(NUM_KEYS)) u_tail (
        .clk(clk), .wr_en(tail_we), .wr_addr(tail_waddr), .wr_data(tail_wdata),
        .rd_addr(tail_raddr), .rd_data(tail_rdata)
    );

    // group of key flags under the search pointer, lowest set bit
    always_comb
    begin
        flags_pad = '0;
        flags_pad[NUM_KEYS-1:0] = nonempty_reg;
        grp_bits = flags_pad[grp_reg*GROUP +: GROUP];
        grp_enc = 4'd0;
        for (int i = GROUP - 1; i >= 0; i--)
        begin
            if (grp_bits[i])
            begin
                grp_enc = 4'(i);
            end
        end
        found_key = KEY_W'({grp_reg, grp_enc});
    end

    assign free_valid = (free_reg != CNT_W'(CAPACITY));
    assign new_slot   = free_valid ? SLOT_W'(free_reg) : SLOT_W'(fill_reg);
    assign out_load   = (state_reg == S_DONE) && (!out_valid_reg || !out_stall);

    // sequencer
    always_comb
    begin
        state_next       = state_reg;
        cmd_next         = cmd_reg;
        key_next         = key_reg;
        data_next        = data_reg;
        slot_next        = slot_reg;
        tail_next        = tail_reg;
        from_free_next   = from_free_reg;
        grp_next         = grp_reg;
        nonempty_next    = nonempty_reg;
        free_next        = free_reg;
        fill_next        = fill_reg;
        count_next       = count_reg;
        res_payload_next = res_payload_reg;
        res_key_next     = res_key_reg;
        res_status_next  = res_status_reg;
        out_valid_next   = out_valid_reg && out_stall;

        pay_we     = 1'b0;
        pay_waddr  = slot_reg;
        pay_wdata  = data_reg;
        pay_raddr  = slot_reg;
        link_we    = 1'b0;
        link_waddr = slot_reg;
        link_wdata = free_reg;
        link_raddr = slot_reg;
        head_we    = 1'b0;
        head_waddr = key_reg;
        head_wdata = slot_reg;
        head_raddr = key_reg;
        tail_we    = 1'b0;
        tail_waddr = key_reg;
        tail_wdata = slot_reg;
        tail_raddr = key_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next         = cmd;
                    key_next         = KEY_W'(priority_key);
                    data_next        = PAYLOAD_BITS'(payload_in);
                    res_payload_next = '0;
                    res_key_next     = '0;
                    res_status_next  = ST_OK;
                    state_next       = S_DONE;
                    unique case (cmd)
                        CMD_INSERT:
                        begin
                            if (32'(priority_key) >= NUM_KEYS)
                            begin
                                res_status_next = ST_BAD_KEY;
                            end
                            else if (count_reg == CNT_W'(CAPACITY))
                            begin
                                res_status_next = ST_FULL;
                            end
                            else
                            begin
                                // claim a slot, store data, fetch tail and free link
                                slot_next      = new_slot;
                                from_free_next = free_valid;
                                pay_we         = 1'b1;
                                pay_waddr      = new_slot;
                                pay_wdata      = PAYLOAD_BITS'(payload_in);
                                link_raddr     = new_slot;
                                tail_raddr     = KEY_W'(priority_key);
                                state_next     = S_INS;
                            end
                        end
                        CMD_REMOVE:
                        begin
                            if (count_reg == '0)
                            begin
                                res_status_next = ST_EMPTY;
                            end
                            else
                            begin
                                grp_next   = '0;
                                state_next = S_SCAN;
                            end
                        end
                        CMD_CLEAR:
                        begin
                            nonempty_next = '0;
                            free_next     = CNT_W'(CAPACITY);
                            fill_next     = '0;
                            count_next    = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_INS:
            begin
                // advance allocator, append slot to the bucket list
                if (from_free_reg)
                begin
                    free_next = link_rdata;
                end
                else
                begin
                    fill_next = fill_reg + 1'b1;
                end
                if (nonempty_reg[key_reg])
                begin
                    link_we    = 1'b1;
                    link_waddr = tail_rdata;
                    link_wdata = CNT_W'(slot_reg);
                end
                else
                begin
                    head_we = 1'b1;
                    nonempty_next[key_reg] = 1'b1;
                end
                tail_we    = 1'b1;
                count_next = count_reg + 1'b1;
                state_next = S_DONE;
            end
            S_SCAN:
            begin
                if (|grp_bits)
                begin
                    key_next   = found_key;
                    head_raddr = found_key;
                    tail_raddr = found_key;
                    state_next = S_RM1;
                end
                else if (grp_reg == GRP_W'(NGROUPS - 1))
                begin
                    res_status_next = ST_EMPTY;
                    state_next      = S_DONE;
                end
                else
                begin
                    grp_next = grp_reg + 1'b1;
                end
            end
            S_RM1:
            begin
                // head slot known: fetch its data and link
                slot_next  = head_rdata;
                tail_next  = tail_rdata;
                pay_raddr  = head_rdata;
                link_raddr = head_rdata;
                state_next = S_RM2;
            end
            S_RM2:
            begin
                res_payload_next = pay_rdata;
                res_key_next     = key_reg;
                if (slot_reg == tail_reg)
                begin
                    nonempty_next[key_reg] = 1'b0;
                end
                else
                begin
                    head_we    = 1'b1;
                    head_wdata = SLOT_W'(link_rdata);
                end
                // push released slot onto the free chain
                link_we    = 1'b1;
                link_waddr = slot_reg;
                link_wdata = free_reg;
                free_next  = CNT_W'(slot_reg);
                count_next = count_reg - 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            nonempty_reg  <= '0;
            free_reg      <= CNT_W'(CAPACITY);
            fill_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            from_free_reg <= 1'b0;
            grp_reg       <= '0;
            cmd_reg       <= CMD_INSERT;
        end
        else
        begin
            state_reg     <= state_next;
            nonempty_reg  <= nonempty_next;
            free_reg      <= free_next;
            fill_reg      <= fill_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            from_free_reg <= from_free_next;
            grp_reg       <= grp_next;
            cmd_reg       <= cmd_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        key_reg         <= key_next;
        data_reg        <= data_next;
        slot_reg        <= slot_next;
        tail_reg        <= tail_next;
        res_payload_reg <= res_payload_next;
        res_key_reg     <= res_key_next;
        res_status_reg  <= res_status_next;
        if (out_load)
        begin
            out_payload_reg <= res_payload_reg;
            out_key_reg     <= res_key_reg;
            out_count_reg   <= count_reg;
            out_status_reg  <= res_status_reg;
        end
    end

    assign in_stall    = (state_reg != S_IDLE);
    assign out_valid   = out_valid_reg;
    assign payload_out = 32'(out_payload_reg);
    assign key_out     = 8'(out_key_reg);
    assign queue_empty = (out_count_reg == '0);
    assign entry_count = 11'(out_count_reg);
    assign status      = out_status_reg;

endmodule
